@@ hdl/kad_pkg.sv @@
// ----------------------------------------------------------------------------
// kad_pkg
// Shared types and constants for the key auto-repeat and direction block.
// ----------------------------------------------------------------------------
package kad_pkg;

  localparam int KAD_KEY_COUNT  = 256;
  localparam int KAD_COUNT_BITS = 16;

  localparam int KEY_W       = 8;
  localparam int TICK_W      = 16;
  localparam int DIR_W       = 4;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_DELAY = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD      = 1'b1;

  localparam logic [CFG_W-1:0] START_DELAY_RESET = 16'd20;
  localparam logic [CFG_W-1:0] PERIOD_RESET      = 16'd10;

  // commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // keypad direction codes
  localparam logic [DIR_W-1:0] DIR_NONE       = 4'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd4;
  localparam logic [DIR_W-1:0] DIR_CENTER     = 4'd5;
  localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd6;
  localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd7;
  localparam logic [DIR_W-1:0] DIR_UP         = 4'd8;
  localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd9;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key_index;
    logic             key_down;
    logic [DIR_W-1:0] dir_group;
    logic             frame_end;
  } sample_t;

  typedef struct packed {
    logic [KEY_W-1:0]  out_key;
    logic [TICK_W-1:0] held_ticks;
    logic              is_triggered;
    logic              is_repeated;
    logic              is_released;
    logic [DIR_W-1:0]  dir4;
    logic [DIR_W-1:0]  dir8;
    logic              dir_valid;
  } result_t;

  // control from the sequencer to the direction unit
  typedef struct packed {
    logic             clear;
    logic             update;
    logic             resolve;
    logic [DIR_W-1:0] grp;
  } dir_ctl_t;

endpackage

@@ hdl/kad_if.sv @@
// ----------------------------------------------------------------------------
// kad_if
// Valid/ready channels for key samples and results.
// ----------------------------------------------------------------------------
interface kad_sample_if import kad_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface kad_result_if import kad_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/kad_ram.sv @@
// ----------------------------------------------------------------------------
// kad_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/kad_rem.sv @@
// ----------------------------------------------------------------------------
// kad_rem
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module kad_rem #(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic                  rem_zero
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVISOR_W:0]    shifted;
  logic [STEP_W-1:0]     steps;
  logic                  busy;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    shifted = {rem, dvd[DIVIDEND_W-1]};
    if (shifted >= {1'b0, dsr}) begin
      rem_next = DIVISOR_W'(shifted - {1'b0, dsr});
    end else begin
      rem_next = DIVISOR_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= rem_next;
    end
  end

  assign rem_zero = (rem == '0);

endmodule

@@ hdl/kad_dir.sv @@
// ----------------------------------------------------------------------------
// kad_dir
// Per-group held maxima and the 4-way / 8-way direction resolver.
// ----------------------------------------------------------------------------
module kad_dir import kad_pkg::*; #(
  parameter int COUNT_BITS = KAD_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dir_ctl_t              ctl,
  input  logic [COUNT_BITS-1:0] cnt,
  output logic [DIR_W-1:0]      dir4,
  output logic [DIR_W-1:0]      dir8
);

  localparam logic [DIR_W-1:0] ORTHO [4] = '{DIR_DOWN, DIR_LEFT, DIR_RIGHT, DIR_UP};

  logic [COUNT_BITS-1:0] gmax [1:9];
  logic [DIR_W-1:0]      dir4_last;
  logic [DIR_W-1:0]      dir8_last;
  logic [DIR_W-1:0]      res4;
  logic [DIR_W-1:0]      res8;
  logic [COUNT_BITS-1:0] best;
  logic                  grp_ok;
  logic                  a2, a4, a6, a8;
  logic                  d1, d3, d7, d9;

  assign grp_ok = ctl.grp inside {DIR_DOWN_LEFT, DIR_DOWN, DIR_DOWN_RIGHT, DIR_LEFT,
                                  DIR_RIGHT, DIR_UP_LEFT, DIR_UP, DIR_UP_RIGHT};

  always_comb begin
    a2 = gmax[DIR_DOWN]  != '0;
    a4 = gmax[DIR_LEFT]  != '0;
    a6 = gmax[DIR_RIGHT] != '0;
    a8 = gmax[DIR_UP]    != '0;
    d1 = (gmax[DIR_DOWN_LEFT]  != '0) || (a2 && a4);
    d3 = (gmax[DIR_DOWN_RIGHT] != '0) || (a2 && a6);
    d7 = (gmax[DIR_UP_LEFT]    != '0) || (a8 && a4);
    d9 = (gmax[DIR_UP_RIGHT]   != '0) || (a8 && a6);
    res4 = DIR_NONE;
    res8 = DIR_NONE;
    best = '0;
    if (!(a2 && a8) && !(a4 && a6)) begin
      // most recent press: smallest nonzero count, first wins a tie
      for (int i = 0; i < 4; i++) begin
        if (gmax[ORTHO[i]] != '0 && (best == '0 || gmax[ORTHO[i]] < best)) begin
          res4 = ORTHO[i];
          best = gmax[ORTHO[i]];
        end
      end
      if (d9) begin
        res8 = DIR_UP_RIGHT;
      end else if (d7) begin
        res8 = DIR_UP_LEFT;
      end else if (d3) begin
        res8 = DIR_DOWN_RIGHT;
      end else if (d1) begin
        res8 = DIR_DOWN_LEFT;
      end else begin
        res8 = res4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 1; i <= 9; i++) begin
        gmax[i] <= '0;
      end
      dir4_last <= DIR_NONE;
      dir8_last <= DIR_NONE;
    end else if (ctl.resolve) begin
      for (int i = 1; i <= 9; i++) begin
        gmax[i] <= '0;
      end
      dir4_last <= res4;
      dir8_last <= res8;
    end else if (ctl.update && grp_ok && cnt > gmax[ctl.grp]) begin
      gmax[ctl.grp] <= cnt;
    end
  end

  // show the fresh resolution in the cycle it is taken
  assign dir4 = ctl.resolve ? res4 : dir4_last;
  assign dir8 = ctl.resolve ? res8 : dir8_last;

  a_dir8_follows_dir4: assert property (@(posedge clk) disable iff (rst)
    dir4_last != DIR_NONE |-> dir8_last != DIR_NONE)
    else $error("8-way direction empty while 4-way direction is set");

  a_center_never_held: assert property (@(posedge clk) disable iff (rst)
    gmax[DIR_CENTER] == '0)
    else $error("center group collected a held count");

endmodule

@@ hdl/key_autorepeat_and_direction_top.sv @@
// ----------------------------------------------------------------------------
// key_autorepeat_and_direction_top
// Key auto-repeat and keypad direction resolver around a held-count RAM.
// ----------------------------------------------------------------------------
// Flow: an accepted sample passes through the update state, the remainder
//   wait state when the repeat test needs the serial remainder, and the
//   finish state, where the result is registered once the result register
//   is free. One sample is in flight: the next is taken only back in idle.
// Reset and the clear command sweep the held-count RAM, every address, with
//   no sample taken meanwhile; configuration writes are taken at any time.
module key_autorepeat_and_direction_top import kad_pkg::*; #(
  parameter int KEY_COUNT  = KAD_KEY_COUNT,
  parameter int COUNT_BITS = KAD_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  kad_sample_if.sink             sample,
  kad_result_if.source           result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int ADDR_W = $clog2(KEY_COUNT);
  localparam int CMP_W  = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TICK_W-1:0]     TICK_MAX  = '1;
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(KEY_COUNT - 1);

  // sequencer states
  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]            state;
  logic [CFG_W-1:0]      start_delay;
  logic [CFG_W-1:0]      period;
  sample_t               item;
  logic                  key_ok;
  logic [COUNT_BITS-1:0] cnt;
  logic                  trig;
  logic                  rep;
  logic                  rel;
  logic [ADDR_W-1:0]     sweep_addr;
  result_t               res;
  logic                  res_valid;

  logic                  accept;
  logic                  key_fits;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic [COUNT_BITS-1:0] cnt_next;
  logic                  rel_next;
  logic                  need_div;
  logic                  can_load;
  logic                  is_clear;
  logic                  rem_start;
  logic                  rem_done;
  logic                  rem_zero;
  logic [TICK_W-1:0]     held_sat;
  dir_ctl_t              dir_ctl;
  logic [DIR_W-1:0]      dir4;
  logic [DIR_W-1:0]      dir8;

  // --------------------------------------------------------------------------
  // Input handshake: one sample in flight, taken only from idle
  // --------------------------------------------------------------------------
  assign sample.ready = (state == ST_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign key_fits     = (32'(sample.payload.key_index) < KEY_COUNT);
  assign rd_addr      = ADDR_W'(sample.payload.key_index);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay <= START_DELAY_RESET;
      period      <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_DELAY: start_delay <= cfg_data;
        REG_PERIOD:      period      <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Held-count store: read on accept, written back in the update cycle or
  // by the clearing sweep
  // --------------------------------------------------------------------------
  kad_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (KEY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // Advance the held count, saturating; drop it to zero on key up.
  always_comb begin
    cnt_next = '0;
    rel_next = 1'b0;
    if (key_ok) begin
      if (item.key_down) begin
        cnt_next = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
      end else begin
        rel_next = (mem_rdata != '0);
      end
    end
  end

  // Auto-repeat beyond the first tick needs the remainder unit.
  assign need_div = (item.cmd == CMD_SAMPLE) && key_ok && (cnt_next > COUNT_BITS'(1)) &&
                    (period != '0) && (CMP_W'(cnt_next) >= CMP_W'(start_delay));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(item.key_index);
    mem_wdata = cnt_next;
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end else if (state == ST_UPDATE && item.cmd == CMD_SAMPLE && key_ok) begin
      mem_we = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Serial remainder for the repeat-period test
  // --------------------------------------------------------------------------
  assign rem_start = (state == ST_UPDATE) && need_div;

  kad_rem #(
    .DIVIDEND_W (COUNT_BITS),
    .DIVISOR_W  (CFG_W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (cnt_next),
    .divisor  (period),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  // --------------------------------------------------------------------------
  // Direction groups: fold in the new count, resolve at frame end
  // --------------------------------------------------------------------------
  assign can_load = !res_valid || result.ready;
  assign is_clear = (item.cmd == CMD_CLEAR);

  always_comb begin
    dir_ctl.clear   = (state == ST_FIN) && can_load && is_clear;
    dir_ctl.update  = (state == ST_UPDATE) && !is_clear && key_ok;
    dir_ctl.resolve = (state == ST_FIN) && can_load && !is_clear && item.frame_end;
    dir_ctl.grp     = item.dir_group;
  end

  kad_dir #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dir (
    .clk  (clk),
    .rst  (rst),
    .ctl  (dir_ctl),
    .cnt  (cnt_next),
    .dir4 (dir4),
    .dir8 (dir8)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
    end else begin
      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= need_div ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (rem_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (can_load) begin
            // a clear command wipes the store before the next sample
            if (is_clear) begin
              state      <= ST_SWEEP;
              sweep_addr <= '0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the sample and the per-key flags while the item is worked on.
  always_ff @(posedge clk) begin
    if (accept) begin
      item   <= sample.payload;
      key_ok <= key_fits;
    end
    if (state == ST_UPDATE) begin
      cnt  <= cnt_next;
      trig <= (cnt_next == COUNT_BITS'(1));
      rep  <= (cnt_next == COUNT_BITS'(1));
      rel  <= rel_next;
    end else if (state == ST_DIV && rem_done) begin
      rep <= rem_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: holds the last transaction until the sink takes it
  // --------------------------------------------------------------------------
  assign held_sat = (CMP_W'(cnt) > CMP_W'(TICK_MAX)) ? TICK_MAX : TICK_W'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FIN && can_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && can_load) begin
      res.out_key <= item.key_index;
      if (is_clear) begin
        res.held_ticks   <= '0;
        res.is_triggered <= 1'b0;
        res.is_repeated  <= 1'b0;
        res.is_released  <= 1'b0;
        res.dir4         <= DIR_NONE;
        res.dir8         <= DIR_NONE;
        res.dir_valid    <= 1'b0;
      end else begin
        res.held_ticks   <= held_sat;
        res.is_triggered <= trig;
        res.is_repeated  <= rep;
        res.is_released  <= rel;
        res.dir4         <= dir4;
        res.dir8         <= dir8;
        res.dir_valid    <= item.frame_end;
      end
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_reset_sweeps: assert property (@(posedge clk)
    rst |=> state == ST_SWEEP)
    else $error("reset did not start the clearing sweep");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mem_we)
    else $error("held-count store written while idle");

  a_rem_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == ST_DIV)
    else $error("remainder finished outside the wait state");

  a_release_is_up: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_released |-> res.held_ticks == '0)
    else $error("release reported with a nonzero held count");

  a_trigger_repeats: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_triggered |-> res.is_repeated && res.held_ticks == TICK_W'(1))
    else $error("first-tick result without repeat or with a wrong count");

endmodule
